// ===== rtl/rssp_pkg.sv =====
package rssp_pkg;

    localparam int unsigned MAX_ENTRIES_DEF = 8;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned RECT_W  = 4 * COORD_W;
    localparam int unsigned MAG_W   = COORD_W;
    localparam int unsigned SQ_W    = 2 * MAG_W;
    localparam int unsigned DIST_W  = 34;
    localparam int unsigned SEED_W  = 3;

    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 48;
    localparam int unsigned OUT_USED_W = 2 * SEED_W + DIST_W + 1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic issue;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic few;
        logic last_pair;
        logic busy;
    } t_status;

endpackage

// ===== rtl/rssp_ctrl.sv =====
module rssp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  rssp_pkg::t_status i_status,
    output rssp_pkg::t_cmd    o_cmd
);
    import rssp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;

    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (w_accept && i_in_last) n_state = S_START;
            end
            S_START: begin
                n_state = i_status.few ? S_FINISH : S_SCAN;
            end
            S_SCAN: begin
                if (i_status.last_pair) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!i_status.busy) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (o_cmd.publish) n_state = S_LOAD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_in_ready    = (r_state == S_LOAD);
        o_cmd.load    = w_accept;
        o_cmd.start   = (r_state == S_START);
        o_cmd.issue   = (r_state == S_SCAN);
        // The result register is free once it is empty or being taken.
        o_cmd.publish = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/rssp_dpath.sv =====
module rssp_dpath #(
    parameter int unsigned MAX_ENTRIES = rssp_pkg::MAX_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rssp_pkg::t_cmd                i_cmd,
    output rssp_pkg::t_status             o_status,
    input  logic [rssp_pkg::RECT_W-1:0]   i_rect,
    output logic [rssp_pkg::SEED_W-1:0]   o_seed_first,
    output logic [rssp_pkg::SEED_W-1:0]   o_seed_second,
    output logic [rssp_pkg::DIST_W-1:0]   o_pair_distance,
    output logic                          o_overflowed
);
    import rssp_pkg::*;

    localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned EXT_W = (IDX_W > SEED_W) ? IDX_W : SEED_W;

    logic [RECT_W-1:0] r_mem [MAX_ENTRIES];

    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;
    logic             w_j_end;
    logic             w_last_pair;
    logic             w_room;

    // Pipeline: read, corner magnitudes, squares, sum, compare.
    logic              r_v1, r_v2, r_v3, r_v4;
    logic [IDX_W-1:0]  r_i1, r_j1, r_i2, r_j2, r_i3, r_j3, r_i4, r_j4;
    logic [RECT_W-1:0] r_rd_a, r_rd_b;
    logic [MAG_W-1:0]  r_mag [4];
    logic [MAG_W-1:0]  n_mag [4];
    logic [SQ_W-1:0]   r_sq [4];
    logic [DIST_W-1:0] r_sum;

    logic              r_found;
    logic [DIST_W-1:0] r_best;
    logic [IDX_W-1:0]  r_s1, r_s2;

    logic [SEED_W-1:0] r_out_s1, r_out_s2;
    logic [DIST_W-1:0] r_out_dist;
    logic              r_out_ovf;
    logic [EXT_W-1:0]  w_s1_ext, w_s2_ext;

    assign w_room      = (r_count < CNT_W'(MAX_ENTRIES));
    assign w_j_end     = ((CNT_W'(r_j) + CNT_W'(1)) == r_count);
    assign w_last_pair = w_j_end && ((CNT_W'(r_i) + CNT_W'(2)) == r_count);

    assign o_status.few       = (r_count < CNT_W'(2));
    assign o_status.last_pair = w_last_pair;
    assign o_status.busy      = r_v1 || r_v2 || r_v3 || r_v4;

    // Rectangle store: one write port, two read ports with registered data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_room) r_mem[r_count[IDX_W-1:0]] <= i_rect;
        r_rd_a <= r_mem[r_i];
        r_rd_b <= r_mem[r_j];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.publish) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.load) begin
            if (w_room) begin
                r_count <= r_count + CNT_W'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_i <= '0;
            r_j <= IDX_W'(1);
        end else if (i_cmd.issue) begin
            if (w_j_end) begin
                r_i <= r_i + IDX_W'(1);
                r_j <= r_i + IDX_W'(2);
            end else begin
                r_j <= r_j + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_comb begin
        logic signed [COORD_W:0] d;
        for (int k = 0; k < 4; k++) begin
            d = {r_rd_a[k*COORD_W + COORD_W-1], r_rd_a[k*COORD_W +: COORD_W]}
              - {r_rd_b[k*COORD_W + COORD_W-1], r_rd_b[k*COORD_W +: COORD_W]};
            n_mag[k] = d[COORD_W] ? MAG_W'(-d) : MAG_W'(d);
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1 <= r_i;
        r_j1 <= r_j;
        r_i2 <= r_i1;
        r_j2 <= r_j1;
        r_i3 <= r_i2;
        r_j3 <= r_j2;
        r_i4 <= r_i3;
        r_j4 <= r_j3;
        for (int k = 0; k < 4; k++) begin
            r_mag[k] <= n_mag[k];
            r_sq[k]  <= r_mag[k] * r_mag[k];
        end
        r_sum <= (DIST_W'(r_sq[0]) + DIST_W'(r_sq[1]))
               + (DIST_W'(r_sq[2]) + DIST_W'(r_sq[3]));
    end

    // Strictly greater replaces, so the earliest pair in scan order wins a tie.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_best  <= '0;
            r_s1    <= '0;
            r_s2    <= '0;
        end else if (i_cmd.start) begin
            r_found <= 1'b0;
            r_best  <= '0;
            r_s1    <= '0;
            r_s2    <= '0;
        end else if (r_v4 && (!r_found || (r_sum > r_best))) begin
            r_found <= 1'b1;
            r_best  <= r_sum;
            r_s1    <= r_i4;
            r_s2    <= r_j4;
        end
    end

    assign w_s1_ext = EXT_W'(r_s1);
    assign w_s2_ext = EXT_W'(r_s2);

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_s1   <= w_s1_ext[SEED_W-1:0];
            r_out_s2   <= w_s2_ext[SEED_W-1:0];
            r_out_dist <= r_best;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_seed_first    = r_out_s1;
    assign o_seed_second   = r_out_s2;
    assign o_pair_distance = r_out_dist;
    assign o_overflowed    = r_out_ovf;

endmodule

// ===== rtl/rect_split_seed_pick_unit.sv =====
// Channel   Dir  Payload
// s_axis    in   tdata: x_low, y_low, x_high, y_high; tlast: last rectangle of the set
// m_axis    out  tdata: seed_first, seed_second, pair_distance, overflowed
//
// Rectangles are loaded while no search is running. After the last one the search
// reads every pair of stored rectangles once (none when fewer than two are stored):
// one pair is read per cycle from the two read ports of the rectangle store
// and flows through a five-stage distance and compare pipeline.
// Reset is synchronous and active low; it empties the store and the result register.
// A result waiting on m_axis does not stop loading of the next set; only the
// hand-off of the following result waits for it to be taken.
module rect_split_seed_pick_unit #(
    parameter int unsigned MAX_ENTRIES = rssp_pkg::MAX_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] x_low, [31:16] y_low, [47:32] x_high, [63:48] y_high
    input  logic [rssp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [2:0] seed_first, [5:3] seed_second, [39:6] pair_distance, [40] overflowed
    output logic [rssp_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import rssp_pkg::*;

    t_cmd              w_cmd;
    t_status           w_status;
    logic [SEED_W-1:0] w_seed_first;
    logic [SEED_W-1:0] w_seed_second;
    logic [DIST_W-1:0] w_pair_distance;
    logic              w_overflowed;

    rssp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    rssp_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_rect          (s_axis_tdata[RECT_W-1:0]),
        .o_seed_first    (w_seed_first),
        .o_seed_second   (w_seed_second),
        .o_pair_distance (w_pair_distance),
        .o_overflowed    (w_overflowed)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - OUT_USED_W){1'b0}},
                           w_overflowed, w_pair_distance, w_seed_second, w_seed_first};

endmodule
